/* src/rrb_pkg.sv */
// ----------------------------------------------------------------------------
// Record ring buffer package
// Shared constants, codes and types of the record ring buffer with wrap padding.
// ----------------------------------------------------------------------------
package rrb_pkg;

    // Record format: one header word, then the payload words.
    localparam int ALIGN_BYTES = 8;
    localparam int MAX_PAYLOAD = 504;
    localparam int LEN_W       = 9;
    localparam int TYPE_W      = 2;
    localparam int WORD_W      = 64;
    localparam int MSG_W       = 7;   // record length in words, header included
    localparam int PAY_W       = 6;   // payload words of one record

    // Queue sizes between the parts of the block.
    localparam int CMD_DEPTH   = 4;
    localparam int CMD_PTR_W   = 2;
    localparam int CMD_CNT_W   = 3;
    localparam int OUT_DEPTH   = 4;
    localparam int OUT_PTR_W   = 2;
    localparam int OUT_CNT_W   = 3;

    // Record types and filter settings.
    localparam logic [TYPE_W-1:0] TYPE_PAD   = 2'd0;
    localparam logic [TYPE_W-1:0] TYPE_STOP  = 2'd3;
    localparam logic [TYPE_W-1:0] FILTER_ALL = 2'd0;

    typedef enum logic [1:0] {
        KIND_SEND = 2'd0,
        KIND_WORD = 2'd1,
        KIND_RECV = 2'd2,
        KIND_NONE = 2'd3
    } kind_t;

    typedef enum logic [3:0] {
        ST_ACCEPTED   = 4'd0,
        ST_FULL       = 4'd1,
        ST_TOO_LARGE  = 4'd2,
        ST_STORED     = 4'd3,
        ST_OUT_OF_SEQ = 4'd4,
        ST_EMPTY      = 4'd5,
        ST_FILTERED   = 4'd6,
        ST_HEADER     = 4'd7,
        ST_WORD       = 4'd8
    } status_t;

    typedef enum logic [2:0] {
        BS_IDLE,
        BS_PAD_WR,
        BS_RX_HDR_RD,
        BS_RX_HDR,
        BS_RX_WORD
    } back_state_t;

    // A classified command as the front hands it to the back.
    typedef struct packed {
        kind_t               kind;
        logic [TYPE_W-1:0]   msg_type;
        logic [LEN_W-1:0]    payload_len;
        logic [MSG_W-1:0]    msg_words;
        logic                len_too_large;
        logic [WORD_W-1:0]   payload_word;
    } cmd_t;

    // One result item.
    typedef struct packed {
        status_t             status;
        logic [TYPE_W-1:0]   out_type;
        logic [LEN_W-1:0]    out_length;
        logic [WORD_W-1:0]   out_word;
        logic                last;
    } res_t;

    // Result push from the back into the output queue.
    typedef struct packed {
        logic push;
        res_t res;
    } res_push_t;

    // Header word: type in the low half, payload byte count in the high half.
    function automatic logic [WORD_W-1:0] make_header(logic [LEN_W-1:0] len,
                                                      logic [TYPE_W-1:0] rtype);
        return {23'd0, len, 30'd0, rtype};
    endfunction

endpackage

/* src/record_ring_buffer_with_wrap_padding_top.sv */
// ----------------------------------------------------------------------------
// Record ring buffer with wrap padding, top level
// Ring of 64-bit words holding typed, variable-length records.
// ----------------------------------------------------------------------------
// The input stream carries one command per transaction, its kind in s_tuser:
// begin send (reserves a record, padding the ring tail when it would not fit),
// payload word (stored in order, the last one commits the record) and receive
// (delivers the next committed record if it passes the type filter). Every
// command gives at least one result transaction on the output stream, the
// final one marked by m_tlast; a receive that delivers a record gives the
// header and then one transaction per payload word.
// The filter type is written on the cfg channel, by the user only while the
// block is idle; the block itself does not enforce this. In the executor, a
// begin send is taken in the idle state, and when a padding record is written
// there the record header follows from a further state; a payload word is
// stored as it is taken; a receive takes the command, then reads and examines
// each record header in turn (padding is skipped) and, for a delivered record
// with payload, reads the payload words one by one, each delivered once the
// single registered read port of the ring memory returns it. A four-entry
// command queue and a four-entry result queue decouple the two sides, so a
// stalled receiver holds back the executor only once the result queue is
// full. Reset empties the ring (all positions to zero), clears both queues
// and sets the filter to deliver all types.
// ----------------------------------------------------------------------------
module record_ring_buffer_with_wrap_padding_top #(
    parameter int RING_BYTES = 512
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,   // msg_type[1:0], payload_len[10:2], payload_word[74:11]
    input  logic [1:0]  s_tuser,   // kind[1:0]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [79:0] m_tdata,   // status[3:0], out_type[5:4], out_length[14:6],
                                   // out_word[78:15]
    output logic        m_tlast,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_data   // filter_type[1:0]
);
    import rrb_pkg::*;

    logic [1:0]           filter_reg;
    logic                 cmd_valid, cmd_ready;
    cmd_t                 cmd;
    res_push_t            res_push;
    logic [OUT_CNT_W-1:0] out_count;

    // Filter register.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filter_reg <= FILTER_ALL;
        end else if (cfg_valid && cfg_ready) begin
            filter_reg <= cfg_data;
        end
    end

    rrb_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    rrb_back #(
        .RING_BYTES (RING_BYTES)
    ) u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .filter_type (filter_reg),
        .cmd_valid   (cmd_valid),
        .cmd_ready   (cmd_ready),
        .cmd         (cmd),
        .out_count   (out_count),
        .out         (res_push)
    );

    rrb_out_queue u_out_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .in       (res_push),
        .count    (out_count),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

/* src/rrb_front.sv */
// ----------------------------------------------------------------------------
// Record ring buffer front end
// Accepts input transactions, decodes and sizes them, and queues the commands.
// ----------------------------------------------------------------------------
module rrb_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [79:0]   s_tdata,   // msg_type[1:0], payload_len[10:2], payload_word[74:11]
    input  logic [1:0]    s_tuser,   // kind[1:0]
    output logic          cmd_valid,
    input  logic          cmd_ready,
    output rrb_pkg::cmd_t cmd
);
    import rrb_pkg::*;

    cmd_t                 q_reg [CMD_DEPTH];
    logic [CMD_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [CMD_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CMD_CNT_W-1:0] count_reg, count_next;

    kind_t            in_kind;
    logic [LEN_W-1:0] in_len;
    logic [LEN_W:0]   len_round;
    logic [MSG_W-1:0] pay_words;
    cmd_t             in_cmd;
    logic             push, pop;

    // Decode the transaction and work out the record size in words.
    always_comb begin
        in_kind   = kind_t'(s_tuser);
        in_len    = s_tdata[10:2];
        len_round = {1'b0, in_len} + (LEN_W+1)'(7);
        pay_words = len_round[LEN_W:3];
        in_cmd.kind          = in_kind;
        in_cmd.msg_type      = s_tdata[1:0];
        in_cmd.payload_len   = in_len;
        in_cmd.msg_words     = pay_words + MSG_W'(1);
        in_cmd.len_too_large = (in_len > LEN_W'(MAX_PAYLOAD));
        in_cmd.payload_word  = s_tdata[74:11];
    end

    // Command queue handshake; an unknown kind is taken and dropped.
    assign s_tready  = (count_reg != CMD_CNT_W'(CMD_DEPTH));
    assign push      = s_tvalid && s_tready && (in_kind != KIND_NONE);
    assign cmd_valid = (count_reg != '0);
    assign pop       = cmd_valid && cmd_ready;
    assign cmd       = q_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = push ? wr_ptr_reg + CMD_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop  ? rd_ptr_reg + CMD_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + CMD_CNT_W'(push) - CMD_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (push) begin
            q_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

/* src/rrb_back.sv */
// ----------------------------------------------------------------------------
// Record ring buffer back end
// Executes queued commands against the ring memory and its positions.
// ----------------------------------------------------------------------------
module rrb_back #(
    parameter int RING_BYTES = 512
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic [1:0]                       filter_type,
    input  logic                             cmd_valid,
    output logic                             cmd_ready,
    input  rrb_pkg::cmd_t                    cmd,
    input  logic [rrb_pkg::OUT_CNT_W-1:0]    out_count,
    output rrb_pkg::res_push_t               out
);
    import rrb_pkg::*;

    localparam int RW   = RING_BYTES / ALIGN_BYTES;
    localparam int SPAN = 2 * RW;
    localparam int AW   = $clog2(RW);
    localparam int PW   = $clog2(SPAN);
    localparam int CW   = (PW + 1 > 8) ? PW + 1 : 8;
    localparam logic [CW-1:0] RW_C   = CW'(RW);
    localparam logic [CW-1:0] SPAN_C = CW'(SPAN);

    function automatic logic [CW-1:0] pos_add(logic [CW-1:0] p, logic [CW-1:0] n);
        logic [CW-1:0] s;
        s = p + n;
        return (s >= SPAN_C) ? s - SPAN_C : s;
    endfunction

    function automatic logic [CW-1:0] pos_diff(logic [CW-1:0] a, logic [CW-1:0] b);
        logic [CW-1:0] d;
        d = a + SPAN_C - b;
        return (d >= SPAN_C) ? d - SPAN_C : d;
    endfunction

    function automatic logic [CW-1:0] ring_off(logic [CW-1:0] p);
        return (p >= RW_C) ? p - RW_C : p;
    endfunction

    function automatic logic [AW-1:0] wrap_inc(logic [AW-1:0] a);
        logic [CW-1:0] s;
        s = CW'(a) + CW'(1);
        return (s == RW_C) ? '0 : s[AW-1:0];
    endfunction

    // Ring memory.
    logic [WORD_W-1:0] mem [RW];
    logic              mem_we, mem_re;
    logic [AW-1:0]     mem_waddr, mem_raddr;
    logic [WORD_W-1:0] mem_wdata;
    logic [WORD_W-1:0] rd_data_reg;

    // Control state.
    back_state_t       state_reg, state_next;
    logic [PW-1:0]     reserve_reg, reserve_next;
    logic [PW-1:0]     commit_reg, commit_next;
    logic [PW-1:0]     read_reg, read_next;
    logic [AW-1:0]     write_ptr_reg, write_ptr_next;
    logic [PAY_W-1:0]  words_left_reg, words_left_next;
    logic              rd_pend_reg, rd_pend_next;

    // Working registers.
    logic [LEN_W-1:0]  hdr_len_reg, hdr_len_next;
    logic [TYPE_W-1:0] hdr_type_reg, hdr_type_next;
    logic [CW-1:0]     avail_reg, avail_next;
    logic [PAY_W-1:0]  rx_left_reg, rx_left_next;
    logic [AW-1:0]     rx_addr_reg, rx_addr_next;
    logic [TYPE_W-1:0] rx_type_reg, rx_type_next;
    logic [LEN_W-1:0]  rx_len_reg, rx_len_next;
    logic              rd_last_reg, rd_last_next;

    // Send sizing.
    logic [CW-1:0]     reserve_c, read_c, commit_c, msg_c;
    logic [CW-1:0]     used_c, free_c, off_c, tail_c, pad_c, req_c, pad_m1_c;
    logic [CW-1:0]     new_reserve_c;
    logic [PAY_W-1:0]  send_pay;
    logic              too_large, ring_full;

    // Receive decoding.
    logic [CW-1:0]     avail_c, rd_off_c, total_c, next_read_c;
    logic [LEN_W-1:0]  hdr_len;
    logic [TYPE_W-1:0] hdr_type;
    logic              hdr_is_pad, hdr_pass;
    logic [LEN_W:0]    hdr_round;
    logic [MSG_W-1:0]  hdr_pay7;
    logic [PAY_W-1:0]  hdr_pay;
    logic              space;

    // Free space, padding and sizes of the record being reserved.
    always_comb begin
        reserve_c     = CW'(reserve_reg);
        read_c        = CW'(read_reg);
        commit_c      = CW'(commit_reg);
        msg_c         = CW'(cmd.msg_words);
        used_c        = pos_diff(reserve_c, read_c);
        free_c        = RW_C - used_c;
        off_c         = ring_off(reserve_c);
        tail_c        = RW_C - off_c;
        pad_c         = (tail_c < msg_c) ? tail_c : '0;
        pad_m1_c      = pad_c - CW'(1);
        req_c         = pad_c + msg_c;
        new_reserve_c = pos_add(reserve_c, req_c);
        send_pay      = PAY_W'(cmd.msg_words - MSG_W'(1));
        too_large     = cmd.len_too_large || (msg_c > RW_C);
        ring_full     = (free_c < req_c);
    end

    // Header of the record at the read position.
    always_comb begin
        avail_c     = pos_diff(commit_c, read_c);
        rd_off_c    = ring_off(read_c);
        hdr_type    = rd_data_reg[1:0];
        hdr_is_pad  = (rd_data_reg[31:0] == '0);
        hdr_len     = rd_data_reg[40:32];
        hdr_round   = {1'b0, hdr_len} + (LEN_W+1)'(7);
        hdr_pay7    = hdr_round[LEN_W:3];
        total_c     = CW'(hdr_pay7) + CW'(1);
        next_read_c = pos_add(read_c, total_c);
        hdr_pay     = (hdr_pay7 > MSG_W'(63)) ? PAY_W'(63) : hdr_pay7[PAY_W-1:0];
        hdr_pass    = (filter_type == FILTER_ALL) || (hdr_type == filter_type) ||
                      (hdr_type == TYPE_STOP);
        space       = ((OUT_CNT_W+1)'(out_count) + (OUT_CNT_W+1)'(rd_pend_reg)) <
                      (OUT_CNT_W+1)'(OUT_DEPTH);
    end

    // Sequencer: next state, memory accesses and result pushes.
    always_comb begin
        state_next      = state_reg;
        reserve_next    = reserve_reg;
        commit_next     = commit_reg;
        read_next       = read_reg;
        write_ptr_next  = write_ptr_reg;
        words_left_next = words_left_reg;
        rd_pend_next    = 1'b0;
        hdr_len_next    = hdr_len_reg;
        hdr_type_next   = hdr_type_reg;
        avail_next      = avail_reg;
        rx_left_next    = rx_left_reg;
        rx_addr_next    = rx_addr_reg;
        rx_type_next    = rx_type_reg;
        rx_len_next     = rx_len_reg;
        rd_last_next    = rd_last_reg;
        cmd_ready       = 1'b0;
        mem_we          = 1'b0;
        mem_waddr       = '0;
        mem_wdata       = '0;
        mem_re          = 1'b0;
        mem_raddr       = '0;
        out.push           = 1'b0;
        out.res.status     = ST_ACCEPTED;
        out.res.out_type   = '0;
        out.res.out_length = '0;
        out.res.out_word   = '0;
        out.res.last       = 1'b1;

        case (state_reg)
            BS_IDLE: begin
                if (cmd_valid && space) begin
                    cmd_ready = 1'b1;
                    case (cmd.kind)
                        KIND_SEND: begin
                            out.push = 1'b1;
                            if (words_left_reg != '0) begin
                                out.res.status = ST_OUT_OF_SEQ;
                            end else if (too_large) begin
                                out.res.status = ST_TOO_LARGE;
                            end else if (ring_full) begin
                                out.res.status = ST_FULL;
                            end else begin
                                out.res.status = ST_ACCEPTED;
                                mem_we         = 1'b1;
                                mem_waddr      = off_c[AW-1:0];
                                if (pad_c != '0) begin
                                    // Pad the tail; the record goes to the ring start.
                                    mem_wdata      = make_header({pad_m1_c[5:0], 3'b000},
                                                                 TYPE_PAD);
                                    hdr_len_next   = cmd.payload_len;
                                    hdr_type_next  = cmd.msg_type;
                                    write_ptr_next = wrap_inc('0);
                                    state_next     = BS_PAD_WR;
                                end else begin
                                    mem_wdata      = make_header(cmd.payload_len,
                                                                 cmd.msg_type);
                                    write_ptr_next = wrap_inc(off_c[AW-1:0]);
                                end
                                reserve_next    = new_reserve_c[PW-1:0];
                                words_left_next = send_pay;
                                if (send_pay == '0) begin
                                    commit_next = new_reserve_c[PW-1:0];
                                end
                            end
                        end
                        KIND_WORD: begin
                            out.push = 1'b1;
                            if (words_left_reg == '0) begin
                                out.res.status = ST_OUT_OF_SEQ;
                            end else begin
                                out.res.status  = ST_STORED;
                                mem_we          = 1'b1;
                                mem_waddr       = write_ptr_reg;
                                mem_wdata       = cmd.payload_word;
                                write_ptr_next  = wrap_inc(write_ptr_reg);
                                words_left_next = words_left_reg - PAY_W'(1);
                                if (words_left_reg == PAY_W'(1)) begin
                                    commit_next = reserve_reg;
                                end
                            end
                        end
                        KIND_RECV: begin
                            state_next = BS_RX_HDR_RD;
                        end
                        default: begin
                        end
                    endcase
                end
            end

            BS_PAD_WR: begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = make_header(hdr_len_reg, hdr_type_reg);
                state_next = BS_IDLE;
            end

            BS_RX_HDR_RD: begin
                if (space) begin
                    avail_next = avail_c;
                    if (avail_c == '0) begin
                        out.push       = 1'b1;
                        out.res.status = ST_EMPTY;
                        state_next     = BS_IDLE;
                    end else begin
                        mem_re       = 1'b1;
                        mem_raddr    = rd_off_c[AW-1:0];
                        rx_addr_next = wrap_inc(rd_off_c[AW-1:0]);
                        state_next   = BS_RX_HDR;
                    end
                end
            end

            BS_RX_HDR: begin
                if (space) begin
                    if (total_c > avail_reg) begin
                        out.push       = 1'b1;
                        out.res.status = ST_EMPTY;
                        state_next     = BS_IDLE;
                    end else begin
                        read_next = next_read_c[PW-1:0];
                        if (hdr_is_pad) begin
                            // Padding or a typeless record: skip and look again.
                            state_next = BS_RX_HDR_RD;
                        end else if (!hdr_pass) begin
                            out.push       = 1'b1;
                            out.res.status = ST_FILTERED;
                            state_next     = BS_IDLE;
                        end else begin
                            out.push           = 1'b1;
                            out.res.status     = ST_HEADER;
                            out.res.out_type   = hdr_type;
                            out.res.out_length = hdr_len;
                            out.res.last       = (hdr_pay == '0);
                            rx_type_next       = hdr_type;
                            rx_len_next        = hdr_len;
                            rx_left_next       = hdr_pay;
                            state_next         = (hdr_pay == '0) ? BS_IDLE : BS_RX_WORD;
                        end
                    end
                end
            end

            BS_RX_WORD: begin
                // A word read in the previous cycle is delivered now.
                if (rd_pend_reg) begin
                    out.push           = 1'b1;
                    out.res.status     = ST_WORD;
                    out.res.out_type   = rx_type_reg;
                    out.res.out_length = rx_len_reg;
                    out.res.out_word   = rd_data_reg;
                    out.res.last       = rd_last_reg;
                end
                if (rx_left_reg == '0) begin
                    state_next = BS_IDLE;
                end else if (space) begin
                    mem_re       = 1'b1;
                    mem_raddr    = rx_addr_reg;
                    rx_addr_next = wrap_inc(rx_addr_reg);
                    rx_left_next = rx_left_reg - PAY_W'(1);
                    rd_pend_next = 1'b1;
                    rd_last_next = (rx_left_reg == PAY_W'(1));
                end
            end

            default: begin
                state_next = BS_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= BS_IDLE;
            reserve_reg    <= '0;
            commit_reg     <= '0;
            read_reg       <= '0;
            write_ptr_reg  <= '0;
            words_left_reg <= '0;
            rd_pend_reg    <= 1'b0;
            rx_left_reg    <= '0;
        end else begin
            state_reg      <= state_next;
            reserve_reg    <= reserve_next;
            commit_reg     <= commit_next;
            read_reg       <= read_next;
            write_ptr_reg  <= write_ptr_next;
            words_left_reg <= words_left_next;
            rd_pend_reg    <= rd_pend_next;
            rx_left_reg    <= rx_left_next;
        end
    end

    // Working registers.
    always_ff @(posedge aclk) begin
        hdr_len_reg  <= hdr_len_next;
        hdr_type_reg <= hdr_type_next;
        avail_reg    <= avail_next;
        rx_addr_reg  <= rx_addr_next;
        rx_type_reg  <= rx_type_next;
        rx_len_reg   <= rx_len_next;
        rd_last_reg  <= rd_last_next;
    end

    // Ring memory write port.
    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_waddr] <= mem_wdata;
        end
    end

    // Ring memory read port with registered data.
    always_ff @(posedge aclk) begin
        if (mem_re) begin
            rd_data_reg <= mem[mem_raddr];
        end
    end

endmodule

/* src/rrb_out_queue.sv */
// ----------------------------------------------------------------------------
// Record ring buffer output queue
// Holds result items until the receiver takes them off the output stream.
// ----------------------------------------------------------------------------
module rrb_out_queue (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  rrb_pkg::res_push_t            in,
    output logic [rrb_pkg::OUT_CNT_W-1:0] count,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [79:0]                   m_tdata,  // status[3:0], out_type[5:4],
                                                    // out_length[14:6], out_word[78:15]
    output logic                          m_tlast
);
    import rrb_pkg::*;

    res_t                 q_reg [OUT_DEPTH];
    logic [OUT_PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [OUT_PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [OUT_CNT_W-1:0] count_reg, count_next;
    res_t                 head;
    logic                 pop;

    // Head of the queue onto the stream.
    assign head     = q_reg[rd_ptr_reg];
    assign count    = count_reg;
    assign m_tvalid = (count_reg != '0);
    assign pop      = m_tvalid && m_tready;
    assign m_tdata  = {1'b0, head.out_word, head.out_length, head.out_type, head.status};
    assign m_tlast  = head.last;

    always_comb begin
        wr_ptr_next = in.push ? wr_ptr_reg + OUT_PTR_W'(1) : wr_ptr_reg;
        rd_ptr_next = pop     ? rd_ptr_reg + OUT_PTR_W'(1) : rd_ptr_reg;
        count_next  = count_reg + OUT_CNT_W'(in.push) - OUT_CNT_W'(pop);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Queue storage.
    always_ff @(posedge aclk) begin
        if (in.push) begin
            q_reg[wr_ptr_reg] <= in.res;
        end
    end

endmodule

/* test/tb_record_ring_buffer_with_wrap_padding_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Testbench for the record ring buffer with wrap padding
// The testbench first walks a short table of commands: refusals, empty
// receives, a skipped type-zero record and unused payload bytes. It then sends
// random phases of mostly well-formed records with random content, under each
// filter setting and several idling patterns, including two long receiver
// hold-offs. Every result transaction is compared field by field with the
// results that a cycle-free copy of the ring predicts.
// ----------------------------------------------------------------------------
module tb_record_ring_buffer_with_wrap_padding_top;

    import rrb_pkg::*;

    localparam int RING_BYTES   = 512;
    localparam int RING_WORDS   = RING_BYTES / ALIGN_BYTES;
    localparam int HOLD_CYCLES  = 400;
    localparam int DRAIN_CYCLES = 40;
    localparam int MAX_GAP      = 60;

    // One row of the directed table; typed rows carry their single result.
    typedef struct packed {
        kind_t       kind;
        logic [1:0]  mtype;
        logic [8:0]  plen;
        logic [63:0] pword;
        logic        typed;
        status_t     status;
    } dir_row_t;

    localparam int DIR_ROWS = 22;
    localparam dir_row_t DIRECTED [DIR_ROWS] = '{
        '{KIND_RECV, 2'd0,   9'd0, 64'h0,                   1'b1, ST_EMPTY},
        '{KIND_WORD, 2'd0,   9'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_OUT_OF_SEQ},
        '{KIND_SEND, 2'd1, 9'd505, 64'h0,                   1'b1, ST_TOO_LARGE},
        '{KIND_SEND, 2'd2, 9'd511, 64'h0,                   1'b1, ST_TOO_LARGE},
        '{KIND_NONE, 2'd3, 9'd511, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0, ST_ACCEPTED},
        '{KIND_SEND, 2'd1,   9'd0, 64'h0,                   1'b1, ST_ACCEPTED},
        '{KIND_RECV, 2'd0,   9'd0, 64'h0,                   1'b0, ST_ACCEPTED},
        '{KIND_SEND, 2'd2, 9'd504, 64'h0,                   1'b1, ST_FULL},
        '{KIND_SEND, 2'd3,   9'd9, 64'h0,                   1'b1, ST_ACCEPTED},
        '{KIND_SEND, 2'd1,   9'd8, 64'h0,                   1'b1, ST_OUT_OF_SEQ},
        '{KIND_RECV, 2'd0,   9'd0, 64'h0,                   1'b1, ST_EMPTY},
        '{KIND_WORD, 2'd0,   9'd0, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1, ST_STORED},
        '{KIND_WORD, 2'd0,   9'd0, 64'hDEAD_BEEF_0000_00AB, 1'b1, ST_STORED},
        '{KIND_RECV, 2'd0,   9'd0, 64'h0,                   1'b0, ST_ACCEPTED},
        '{KIND_SEND, 2'd0,  9'd16, 64'h0,                   1'b1, ST_ACCEPTED},
        '{KIND_WORD, 2'd0,   9'd0, 64'h0123_4567_89AB_CDEF, 1'b1, ST_STORED},
        '{KIND_WORD, 2'd0,   9'd0, 64'h0,                   1'b1, ST_STORED},
        '{KIND_SEND, 2'd2,   9'd1, 64'h0,                   1'b1, ST_ACCEPTED},
        '{KIND_WORD, 2'd0,   9'd0, 64'h8000_0000_0000_0001, 1'b0, ST_ACCEPTED},
        '{KIND_RECV, 2'd0,   9'd0, 64'h0,                   1'b0, ST_ACCEPTED},
        '{KIND_RECV, 2'd0,   9'd0, 64'h0,                   1'b1, ST_EMPTY},
        '{KIND_WORD, 2'd0,   9'd0, 64'h5555_5555_5555_5555, 1'b1, ST_OUT_OF_SEQ}
    };

    // Block ports; the inputs that the bench drives are at known values from time zero.
    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata   = '0;   // msg_type[1:0], payload_len[10:2], payload_word[74:11]
    logic [1:0]  s_tuser   = KIND_NONE;   // kind[1:0]
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;   // status[3:0], out_type[5:4], out_length[14:6], out_word[78:15]
    logic        m_tlast;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_data  = '0;   // filter_type[1:0]

    // Predicted ring contents and positions, at the widths of the block.
    logic [63:0] ring_mem [RING_WORDS];
    logic [6:0]  rsv_pos    = '0;
    logic [6:0]  cmt_pos    = '0;
    logic [6:0]  rd_pos     = '0;
    logic [5:0]  wr_slot    = '0;
    logic [5:0]  words_owed = '0;
    logic [1:0]  filter_sel = FILTER_ALL;

    res_t step_results [$];
    res_t due_results [$];
    int   mismatches    = 0;

    // Idling controls; the percentages and hold requests change only between phases.
    int   tx_idle_pct   = 0;
    int   rx_stall_pct  = 0;
    int   hold_requests = 0;
    int   hold_served   = 0;
    int   hold_left     = 0;

    record_ring_buffer_with_wrap_padding_top #(
        .RING_BYTES(RING_BYTES)
    ) i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tlast   (m_tlast),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    // Clock of 2 ns period.
    always begin
        #1 aclk = 1'b1;
        #1 aclk = 1'b0;
    end

    // Generous limit on the whole run.
    initial begin
        #4_000_000;
        $display("end of test: mismatches");
        $finish;
    end

    function automatic logic [63:0] rand_word();
        return {$urandom, $urandom};
    endfunction

    task automatic push_step(status_t st, logic [1:0] rtype, logic [8:0] rlen,
                             logic [63:0] word, logic fin);
        res_t r;
        r.status     = st;
        r.out_type   = rtype;
        r.out_length = rlen;
        r.out_word   = word;
        r.last       = fin;
        step_results.push_back(r);
    endtask

    // Reserve a record, with a padding record first when the tail is too short.
    task automatic ring_begin(logic [1:0] rtype, logic [8:0] rlen);
        int         pay, msg, off, tail, pad, req, freew, moff;
        logic [6:0] used;
        if (words_owed != 0) begin
            push_step(ST_OUT_OF_SEQ, '0, '0, '0, 1'b1);
            return;
        end
        pay = (int'(rlen) + 7) / 8;
        msg = pay + 1;
        if (int'(rlen) > MAX_PAYLOAD || msg > RING_WORDS) begin
            push_step(ST_TOO_LARGE, '0, '0, '0, 1'b1);
            return;
        end
        used  = rsv_pos - rd_pos;
        freew = RING_WORDS - int'(used);
        off   = int'(rsv_pos) % RING_WORDS;
        tail  = RING_WORDS - off;
        pad   = (tail < msg) ? tail : 0;
        req   = pad + msg;
        if (freew < req) begin
            push_step(ST_FULL, '0, '0, '0, 1'b1);
            return;
        end
        if (pad != 0)
            ring_mem[off] = {32'((pad - 1) * 8), 32'd0};
        moff = (int'(rsv_pos) + pad) % RING_WORDS;
        ring_mem[moff] = {23'd0, rlen, 30'd0, rtype};
        wr_slot    = 6'((moff + 1) % RING_WORDS);
        rsv_pos    = rsv_pos + 7'(req);
        words_owed = 6'(pay);
        if (pay == 0)
            cmt_pos = rsv_pos;
        push_step(ST_ACCEPTED, '0, '0, '0, 1'b1);
    endtask

    // Store one payload word; the last one owed commits the record.
    task automatic ring_word(logic [63:0] word);
        if (words_owed == 0) begin
            push_step(ST_OUT_OF_SEQ, '0, '0, '0, 1'b1);
            return;
        end
        ring_mem[wr_slot] = word;
        wr_slot    = wr_slot + 6'd1;
        words_owed = words_owed - 6'd1;
        if (words_owed == 0)
            cmt_pos = rsv_pos;
        push_step(ST_STORED, '0, '0, '0, 1'b1);
    endtask

    // Skip padding and type-zero records, then deliver or filter one record, or report empty.
    task automatic ring_receive();
        int          guard, off, rtype, rlen, total, pay, i;
        logic [6:0]  avail;
        logic [63:0] hdr;
        for (guard = 0; guard <= RING_WORDS + 1; guard++) begin
            avail = cmt_pos - rd_pos;
            if (avail == 0)
                break;
            off   = int'(rd_pos) % RING_WORDS;
            hdr   = ring_mem[off];
            rtype = int'(hdr[31:0]);
            rlen  = int'(hdr[63:32]);
            total = (rlen + 7) / 8 + 1;
            if (total > int'(avail))
                break;
            rd_pos = rd_pos + 7'(total);
            if (rtype == 0)
                continue;
            if (!(filter_sel == FILTER_ALL || rtype == int'(filter_sel) ||
                  rtype == int'(TYPE_STOP))) begin
                push_step(ST_FILTERED, '0, '0, '0, 1'b1);
                return;
            end
            pay = total - 1;
            if (pay > 63)
                pay = 63;
            push_step(ST_HEADER, 2'(rtype), 9'(rlen), '0, pay == 0);
            for (i = 0; i < pay; i++)
                push_step(ST_WORD, 2'(rtype), 9'(rlen),
                          ring_mem[(off + 1 + i) % RING_WORDS], i == pay - 1);
            return;
        end
        push_step(ST_EMPTY, '0, '0, '0, 1'b1);
    endtask

    task automatic apply_ring_command(kind_t kind, logic [1:0] rtype, logic [8:0] rlen,
                                      logic [63:0] word);
        step_results.delete();
        case (kind)
            KIND_SEND: ring_begin(rtype, rlen);
            KIND_WORD: ring_word(word);
            KIND_RECV: ring_receive();
            default: ;
        endcase
    endtask

    // Offer one command after a random gap and wait for its transaction.
    task automatic send_item(kind_t kind, logic [1:0] rtype, logic [8:0] rlen,
                             logic [63:0] word, logic typed, status_t typed_status);
        int   gap;
        res_t r;
        gap = 0;
        while (gap < MAX_GAP && $urandom_range(99) < tx_idle_pct)
            gap++;
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {5'd0, word, rlen, rtype};
        @(posedge aclk);
        while (!s_tready)
            @(posedge aclk);
        apply_ring_command(kind, rtype, rlen, word);
        if (typed) begin
            r = '0;
            r.status = typed_status;
            r.last   = 1'b1;
            due_results.push_back(r);
        end else begin
            foreach (step_results[i])
                due_results.push_back(step_results[i]);
        end
    endtask

    task automatic send_receive();
        send_item(KIND_RECV, 2'($urandom), 9'($urandom), rand_word(), 1'b0, ST_ACCEPTED);
    endtask

    // Mostly whole records with random content, the rest receives and noise.
    task automatic random_traffic(int n_items);
        int    sent, r, k, rtype, rlen, tail;
        bit    broken, ring_empty;
        kind_t kind;
        sent = 0;
        while (sent < n_items) begin
            r = $urandom_range(99);
            if (r < 75) begin
                rtype      = ($urandom_range(9) == 0) ? 0 : $urandom_range(1, 3);
                tail       = RING_WORDS - int'(rsv_pos) % RING_WORDS;
                ring_empty = (rsv_pos == rd_pos) && (words_owed == 0);
                // Full-ring records only fit at the start of an empty ring.
                if (ring_empty && tail == RING_WORDS && $urandom_range(1) == 1)
                    rlen = MAX_PAYLOAD;
                else if (ring_empty && $urandom_range(3) == 0)
                    rlen = (tail - 1) * 8;
                else if ($urandom_range(19) == 0)
                    rlen = $urandom_range(300, 511);
                else
                    rlen = $urandom_range(0, 64);
                send_item(KIND_SEND, 2'(rtype), 9'(rlen), rand_word(), 1'b0, ST_ACCEPTED);
                sent++;
                broken = ($urandom_range(19) == 0);
                while (words_owed != 0 && !(broken && $urandom_range(1) == 1)) begin
                    send_item(KIND_WORD, 2'($urandom), 9'($urandom), rand_word(),
                              1'b0, ST_ACCEPTED);
                    sent++;
                end
                k = $urandom_range(9);
                if (k < 5) begin
                    send_receive();
                    sent++;
                end
                if (k == 0) begin
                    send_receive();
                    sent++;
                end
            end else if (r < 85) begin
                send_receive();
                sent++;
            end else begin
                kind = kind_t'($urandom_range(3));
                send_item(kind, 2'($urandom), 9'($urandom), rand_word(), 1'b0, ST_ACCEPTED);
                if (kind != KIND_NONE)
                    sent++;
            end
        end
    endtask

    // Stop offering, let every result arrive, then give the block time to settle.
    task automatic wait_until_drained();
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_filter(logic [1:0] filt);
        cfg_valid <= 1'b1;
        cfg_data  <= filt;
        @(posedge aclk);
        while (!cfg_ready)
            @(posedge aclk);
        cfg_valid  <= 1'b0;
        filter_sel = filt;
    endtask

    task automatic run_phase(logic [1:0] filt, int tx_pct, int rx_pct, bit squeeze,
                             int n_items);
        wait_until_drained();
        write_filter(filt);
        tx_idle_pct  = tx_pct;
        rx_stall_pct = rx_pct;
        if (squeeze)
            hold_requests++;
        random_traffic(n_items);
    endtask

    // Receiver: random stalls, and a long hold-off whenever one is requested.
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            m_tready  <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (hold_served != hold_requests) begin
            m_tready    <= 1'b0;
            hold_left   <= HOLD_CYCLES;
            hold_served <= hold_served + 1;
        end else begin
            m_tready <= ($urandom_range(99) >= rx_stall_pct);
        end
    end

    // Compare each result transaction with the oldest predicted result.
    always @(posedge aclk) begin : result_check
        res_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $error("unexpected result transaction: status %0d", m_tdata[3:0]);
                mismatches++;
            end else begin
                want = due_results.pop_front();
                if (m_tdata[3:0] !== want.status) begin
                    $error("status: expected %0d, actual %0d", want.status, m_tdata[3:0]);
                    mismatches++;
                end
                if (m_tdata[5:4] !== want.out_type) begin
                    $error("out_type: expected %0d, actual %0d", want.out_type, m_tdata[5:4]);
                    mismatches++;
                end
                if (m_tdata[14:6] !== want.out_length) begin
                    $error("out_length: expected %0d, actual %0d", want.out_length,
                           m_tdata[14:6]);
                    mismatches++;
                end
                if (m_tdata[78:15] !== want.out_word) begin
                    $error("out_word: expected %h, actual %h", want.out_word, m_tdata[78:15]);
                    mismatches++;
                end
                if (m_tlast !== want.last) begin
                    $error("last: expected %0d, actual %0d", want.last, m_tlast);
                    mismatches++;
                end
            end
        end
    end

    // Main sequence: reset, directed table, then the random phases.
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        for (int i = 0; i < DIR_ROWS; i++)
            send_item(DIRECTED[i].kind, DIRECTED[i].mtype, DIRECTED[i].plen,
                      DIRECTED[i].pword, DIRECTED[i].typed, DIRECTED[i].status);

        run_phase(2'd0,  0,  0, 1'b0, 40);
        run_phase(2'd3, 86,  0, 1'b0, 30);
        run_phase(2'd1,  0, 86, 1'b1, 30);
        run_phase(2'd2, 17, 17, 1'b0, 30);
        run_phase(2'd0,  0, 86, 1'b0, 30);
        run_phase(2'd3,  0,  0, 1'b1, 30);
        run_phase(2'd1, 86,  0, 1'b0, 30);
        run_phase(2'd2,  0,  0, 1'b0, 30);
        wait_until_drained();

        if (mismatches == 0 && due_results.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule

/* files.f */
src/rrb_pkg.sv
src/rrb_front.sv
src/rrb_back.sv
src/rrb_out_queue.sv
src/record_ring_buffer_with_wrap_padding_top.sv
test/tb_record_ring_buffer_with_wrap_padding_top.sv
